>>> rtl/core/loaded_set_random_draw_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the loaded set random draw block
// Checks are sampled on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOADED_SET_RANDOM_DRAW_DEFINES_SVH
`define LOADED_SET_RANDOM_DRAW_DEFINES_SVH

`ifndef SYNTHESIS

`define LSRD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lsrd assertion failed");

`define LSRD_ASSERT_IMPL(lbl, ante, cons) \
    `LSRD_ASSERT(lbl, (ante) |-> (cons))

`else

`define LSRD_ASSERT(lbl, prop)

`define LSRD_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

>>> rtl/core/lsrd_pkg.sv
// ----------------------------------------------------------------------------
// lsrd_pkg
// Types and codes shared by the loaded set random draw block.
// ----------------------------------------------------------------------------
package lsrd_pkg;

    localparam int RAND_BITS  = 31;
    localparam int VALUE_W    = 16;

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [VALUE_W-1:0]   new_value;
        logic [RAND_BITS-1:0] random_word;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] drawn_value;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_RD_I = 6'b000100,
        S_RD_P = 6'b001000,
        S_WR_I = 6'b010000,
        S_WR_P = 6'b100000
    } t_state;

endpackage

>>> rtl/core/lsrd_ram.sv
// ----------------------------------------------------------------------------
// lsrd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lsrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lsrd_mod.sv
// ----------------------------------------------------------------------------
// lsrd_mod
// Restoring remainder unit: random word mod remaining count, one bit a cycle.
// ----------------------------------------------------------------------------
module lsrd_mod #(
    parameter int DW = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lsrd_pkg::RAND_BITS-1:0] i_dividend,
    input  logic [DW-1:0]                  i_divisor,
    output logic                           o_done,
    output logic [DW-1:0]                  o_rem
);

    localparam int CNT_W = $clog2(lsrd_pkg::RAND_BITS + 1);

    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic                           r_done, n_done;
    logic [DW-1:0]                  r_rem, n_rem;
    logic [DW-1:0]                  r_div, n_div;
    logic [lsrd_pkg::RAND_BITS-1:0] r_dvd, n_dvd;
    logic [DW:0]                    trial;
    logic [DW:0]                    diff;

    assign trial = {r_rem, r_dvd[lsrd_pkg::RAND_BITS-1]};
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_dvd  = r_dvd;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt = CNT_W'(lsrd_pkg::RAND_BITS);
            n_rem = '0;
            n_div = i_divisor;
            n_dvd = i_dividend;
        end else if (r_cnt != '0) begin
            // remainder stays below the divisor, so the difference fits DW bits
            n_rem  = (trial >= {1'b0, r_div}) ? diff[DW-1:0] : trial[DW-1:0];
            n_dvd  = {r_dvd[lsrd_pkg::RAND_BITS-2:0], 1'b0};
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_dvd <= n_dvd;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/loaded_set_random_draw.sv
// ----------------------------------------------------------------------------
// loaded_set_random_draw
// Set of values drawn without replacement (incremental Fisher-Yates shuffle).
// ----------------------------------------------------------------------------
// Loads (also into a full store), clear, unused commands and failed draws
// (nothing left) return their result straight in the output register. A
// successful draw passes from transfer to result through the one-bit-per-cycle
// remainder unit (random word mod remaining count), then two reads and two
// writes through the single read port and single write port of the element
// RAM to swap the picked entry with the one at the draw position. A new item
// is taken once the block is idle and the output register is free or being
// emptied. The element store needs no clearing pass: clear only resets the
// fill count and draw position.
module loaded_set_random_draw #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lsrd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lsrd_pkg::t_out_item o_out_item
);

    `include "loaded_set_random_draw_defines.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lsrd_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_fill, n_fill;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_out_valid, n_out_valid;
    lsrd_pkg::t_out_item r_out, n_out;
    logic [AW-1:0]       r_idx, n_idx;
    logic [VALUE_BITS-1:0] r_pick, n_pick;

    logic                  accept;
    logic                  exhausted;
    logic                  full;
    logic                  div_start;
    logic                  div_done;
    logic [CW-1:0]         div_rem;
    logic [CW-1:0]         remaining;
    logic [CW-1:0]         idx_sum;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [31:0]           load_ext;
    logic [31:0]           pick_ext;

    assign o_in_ready = (r_state == lsrd_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign exhausted  = (r_pos >= r_fill);
    assign full       = (r_fill >= CW'(DEPTH));
    assign remaining  = r_fill - r_pos;
    assign div_start  = accept && (i_in_item.cmd == lsrd_pkg::CMD_DRAW) && !exhausted;
    assign idx_sum    = div_rem + r_pos;
    assign load_ext   = 32'(i_in_item.new_value);
    assign pick_ext   = 32'(r_pick);

    lsrd_mod #(
        .DW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in_item.random_word),
        .i_divisor  (remaining),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    lsrd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // read idx first, then the draw position; no writes sit between the reads
    assign ram_raddr = (r_state == lsrd_pkg::S_RD_I) ? r_idx : r_pos[AW-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_fill[AW-1:0];
        ram_wdata = load_ext[VALUE_BITS-1:0];
        unique case (r_state)
            lsrd_pkg::S_WR_I: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
            end
            lsrd_pkg::S_WR_P: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = r_pick;
            end
            default: begin
                ram_we = accept && (i_in_item.cmd == lsrd_pkg::CMD_LOAD) && !full;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_pick      = r_pick;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            lsrd_pkg::S_IDLE: begin
                if (accept) begin
                    n_out.drawn_value = '0;
                    n_out.status      = lsrd_pkg::ST_OK;
                    n_out_valid       = 1'b1;
                    unique case (i_in_item.cmd)
                        lsrd_pkg::CMD_LOAD: begin
                            if (full) begin
                                n_out.status = lsrd_pkg::ST_FULL;
                            end else begin
                                n_fill = r_fill + CW'(1);
                            end
                        end
                        lsrd_pkg::CMD_DRAW: begin
                            if (exhausted) begin
                                n_out.status = lsrd_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = lsrd_pkg::S_DIV;
                            end
                        end
                        lsrd_pkg::CMD_CLEAR: begin
                            n_fill = '0;
                            n_pos  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lsrd_pkg::S_DIV: begin
                if (div_done) begin
                    n_idx   = idx_sum[AW-1:0];
                    n_state = lsrd_pkg::S_RD_I;
                end
            end
            lsrd_pkg::S_RD_I: begin
                n_state = lsrd_pkg::S_RD_P;
            end
            lsrd_pkg::S_RD_P: begin
                n_pick  = ram_rdata;
                n_state = lsrd_pkg::S_WR_I;
            end
            lsrd_pkg::S_WR_I: begin
                n_state = lsrd_pkg::S_WR_P;
            end
            lsrd_pkg::S_WR_P: begin
                n_out.drawn_value = pick_ext[lsrd_pkg::VALUE_W-1:0];
                n_out.status      = lsrd_pkg::ST_OK;
                n_out_valid       = 1'b1;
                n_pos             = r_pos + CW'(1);
                n_state           = lsrd_pkg::S_IDLE;
            end
            default: begin
                n_state = lsrd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsrd_pkg::S_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_out  <= n_out;
        r_idx  <= n_idx;
        r_pick <= n_pick;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `LSRD_ASSERT(a_pos_le_fill, r_pos <= r_fill)
    `LSRD_ASSERT(a_fill_le_depth, r_fill <= CW'(DEPTH))
    `LSRD_ASSERT_IMPL(a_done_in_div, div_done, r_state == lsrd_pkg::S_DIV)
    `LSRD_ASSERT_IMPL(a_out_free_at_swap, r_state == lsrd_pkg::S_WR_P, !r_out_valid)

endmodule
